/* rtl/bsc_pkg.sv */
// Shared constants, codes and types of the B-spline curve evaluator.
package bsc_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int MAX_DEGREE  = 7;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int KNOT_DEPTH  = MAX_POINTS + MAX_DEGREE + 1;

    localparam int PT_AW   = $clog2(MAX_POINTS);
    localparam int KN_AW   = $clog2(KNOT_DEPTH);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int MAG_W   = COORD_WIDTH + 1;
    localparam int ALPHA_W = FRAC_BITS + 1;
    localparam int PROD_W  = MAG_W + ALPHA_W + 1;
    localparam int PT_W    = 4 * COORD_WIDTH;
    localparam int ROUNDS  = 64;
    localparam int RND_W   = $clog2(ROUNDS);
    localparam int CFG_W   = 7;
    localparam int CFG_AW  = 2;

    localparam logic [1:0] OP_LOAD_POINT = 2'd0;
    localparam logic [1:0] OP_LOAD_KNOT  = 2'd1;
    localparam logic [1:0] OP_GEN_KNOTS  = 2'd2;
    localparam logic [1:0] OP_EVALUATE   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_DEGREE  = 2'd3;

    localparam logic [CFG_AW-1:0] REG_DEGREE      = 2'd0;
    localparam logic [CFG_AW-1:0] REG_POINT_COUNT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HAS_Z       = 2'd2;
    localparam logic [CFG_AW-1:0] REG_HAS_M       = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [MAG_W-1:0]     hi;
        logic [FRAC_BITS-1:0] lo;
        logic [MAG_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } div_rsp_t;

endpackage

/* rtl/bsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bsc_div.sv */
// Restoring divider, one quotient bit per cycle: floor({hi, lo} / den), hi < den.
module bsc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bsc_pkg::div_req_t req,
    output bsc_pkg::div_rsp_t rsp
);

    localparam int CW = $clog2(bsc_pkg::FRAC_BITS + 1);

    logic [bsc_pkg::MAG_W-1:0]     rem_reg;
    logic [bsc_pkg::MAG_W-1:0]     den_reg;
    logic [bsc_pkg::FRAC_BITS-1:0] lo_reg;
    logic [bsc_pkg::FRAC_BITS-1:0] quo_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [bsc_pkg::MAG_W:0]       trial;
    logic [bsc_pkg::MAG_W:0]       diff;
    logic                          take;

    assign trial = {rem_reg, lo_reg[bsc_pkg::FRAC_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CW'(1));
            if (req.start)
            begin
                rem_reg  <= req.hi;
                lo_reg   <= req.lo;
                den_reg  <= req.den;
                cnt_reg  <= CW'(bsc_pkg::FRAC_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? diff[bsc_pkg::MAG_W-1:0] : trial[bsc_pkg::MAG_W-1:0];
                quo_reg <= {quo_reg[bsc_pkg::FRAC_BITS-2:0], take};
                lo_reg  <= {lo_reg[bsc_pkg::FRAC_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

    div_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider not busy after start");
    div_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    div_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !req.start |-> rem_reg < den_reg)
        else $error("divider remainder out of range");

endmodule

/* rtl/bspline_curve_evaluator.sv */
// B-spline curve evaluator: point/knot stores, span search and de Boor sequencer.
//
// One word in, one word out. Knot generation writes the n + p + 1 knots,
// taking each interior knot's value from the shared divider. Evaluation
// runs a range check, a binary search (64 rounds at most), a fetch of the
// p + 1 points, and for each of the p(p + 1)/2 interpolations two knot
// reads, one divide for alpha (skipped when alpha is 0 or 1) and four
// multiply-round steps on the single multiplier. The next word is accepted
// once the sequencer is idle, even while the previous result still waits on
// out_stall.
module bspline_curve_evaluator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsc_pkg::CFG_AW-1:0]        cfg_index,
    input  logic [bsc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        opcode,
    input  logic [6:0]                        slot,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] in_x,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] in_y,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] in_z,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] in_m,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] knot_value,
    input  logic signed [bsc_pkg::COORD_WIDTH-1:0] param_t,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bsc_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [bsc_pkg::COORD_WIDTH-1:0] out_y,
    output logic signed [bsc_pkg::COORD_WIDTH-1:0] out_z,
    output logic signed [bsc_pkg::COORD_WIDTH-1:0] out_m,
    output logic [1:0]                        status
);

    localparam int CW = bsc_pkg::COORD_WIDTH;
    localparam int FB = bsc_pkg::FRAC_BITS;
    localparam logic [bsc_pkg::ALPHA_W-1:0] ALPHA_ONE = {1'b1, {FB{1'b0}}};
    localparam logic signed [bsc_pkg::PROD_W-1:0] HALF =
        bsc_pkg::PROD_W'(1) <<< (FB - 1);
    localparam logic signed [CW-1:0] FX_ONE = CW'(1) << FB;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RNG0, ST_RNG1, ST_RNG2, ST_SRCH0, ST_SRCH1, ST_SRCH2,
        ST_LOAD, ST_LOADW, ST_LV0, ST_LV1, ST_K0, ST_K1, ST_K2, ST_DIV,
        ST_MUL, ST_ADD, ST_WR, ST_GEN, ST_GDIV, ST_DONE
    } state_t;

    state_t state_reg;

    logic [bsc_pkg::DEG_W-1:0] degree_reg;
    logic [bsc_pkg::CFG_W-1:0] point_count_reg;
    logic                      has_z_reg;
    logic                      has_m_reg;

    logic signed [CW-1:0]          t_reg;
    logic signed [CW-1:0]          ka_reg;
    logic signed [CW-1:0]          klo_reg;
    logic [bsc_pkg::CNT_W-1:0]     low_reg;
    logic [bsc_pkg::CNT_W-1:0]     high_reg;
    logic [bsc_pkg::CNT_W-1:0]     mid_reg;
    logic [bsc_pkg::CNT_W-1:0]     span_reg;
    logic [bsc_pkg::RND_W-1:0]     rnd_reg;
    logic [bsc_pkg::DEG_W-1:0]     j_reg;
    logic [bsc_pkg::DEG_W-1:0]     lv_reg;
    logic [bsc_pkg::KN_AW-1:0]     i_reg;
    logic [1:0]                    c_reg;
    logic [bsc_pkg::ALPHA_W-1:0]   alpha_reg;
    logic signed [bsc_pkg::PROD_W-1:0] prod_reg;
    logic [bsc_pkg::PT_W-1:0]      p0_reg;
    logic [bsc_pkg::PT_W-1:0]      p1_reg;
    logic [bsc_pkg::PT_W-1:0]      res_reg;
    logic [1:0]                    stat_reg;
    logic                          out_valid_reg;
    logic signed [CW-1:0]          out_x_reg;
    logic signed [CW-1:0]          out_y_reg;
    logic signed [CW-1:0]          out_z_reg;
    logic signed [CW-1:0]          out_m_reg;
    logic [1:0]                    out_stat_reg;

    logic [bsc_pkg::CNT_W-1:0] n_cl;
    logic [bsc_pkg::CNT_W-1:0] p_ext;
    logic                      accept;

    assign n_cl  = (point_count_reg > bsc_pkg::CFG_W'(bsc_pkg::MAX_POINTS))
                 ? bsc_pkg::CNT_W'(bsc_pkg::MAX_POINTS)
                 : bsc_pkg::CNT_W'(point_count_reg);
    assign p_ext = bsc_pkg::CNT_W'(degree_reg);
    assign accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // stores
    logic                         pt_we;
    logic [bsc_pkg::PT_AW-1:0]    pt_raddr;
    logic [bsc_pkg::PT_W-1:0]     pt_rdata;
    logic                         kn_we;
    logic [bsc_pkg::KN_AW-1:0]    kn_waddr;
    logic [CW-1:0]                kn_wdata;
    logic [bsc_pkg::KN_AW-1:0]    kn_raddr;
    logic [CW-1:0]                kn_rdata;
    logic                         wk_we;
    logic [bsc_pkg::DEG_W-1:0]    wk_raddr;
    logic [bsc_pkg::PT_W-1:0]     wk_wdata;
    logic [bsc_pkg::PT_W-1:0]     wk_rdata;

    bsc_ram #(.WIDTH(bsc_pkg::PT_W), .DEPTH(bsc_pkg::MAX_POINTS)) u_points (
        .clk(clk), .we(pt_we), .waddr(slot[bsc_pkg::PT_AW-1:0]),
        .wdata({in_m, in_z, in_y, in_x}), .raddr(pt_raddr), .rdata(pt_rdata));

    bsc_ram #(.WIDTH(CW), .DEPTH(bsc_pkg::KNOT_DEPTH)) u_knots (
        .clk(clk), .we(kn_we), .waddr(kn_waddr), .wdata(kn_wdata),
        .raddr(kn_raddr), .rdata(kn_rdata));

    bsc_ram #(.WIDTH(bsc_pkg::PT_W), .DEPTH(bsc_pkg::MAX_DEGREE + 1)) u_work (
        .clk(clk), .we(wk_we), .waddr(j_reg), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata));

    // divider
    bsc_pkg::div_req_t div_req;
    bsc_pkg::div_rsp_t div_rsp;

    bsc_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    // de Boor alpha terms
    logic signed [bsc_pkg::MAG_W-1:0] num;
    logic signed [bsc_pkg::MAG_W-1:0] den;
    logic [bsc_pkg::MAG_W-1:0]        num_mag;
    logic [bsc_pkg::MAG_W-1:0]        den_mag;
    logic                             alpha_zero;
    logic                             alpha_one;

    assign num = bsc_pkg::MAG_W'(t_reg) - bsc_pkg::MAG_W'(ka_reg);
    assign den = bsc_pkg::MAG_W'($signed(kn_rdata)) - bsc_pkg::MAG_W'(ka_reg);
    assign num_mag = num[bsc_pkg::MAG_W-1] ? -num : num;
    assign den_mag = den[bsc_pkg::MAG_W-1] ? -den : den;
    assign alpha_zero = (den == '0) || (num == '0)
                     || (num[bsc_pkg::MAG_W-1] != den[bsc_pkg::MAG_W-1]);
    assign alpha_one  = num_mag >= den_mag;

    // knot generation terms
    logic [bsc_pkg::KN_AW-1:0] gen_segs;
    logic                      gen_zero;
    logic                      gen_one;
    logic                      gen_last;

    assign gen_segs = bsc_pkg::KN_AW'(n_cl) - bsc_pkg::KN_AW'(degree_reg);
    assign gen_zero = i_reg <= bsc_pkg::KN_AW'(degree_reg);
    assign gen_one  = i_reg >= bsc_pkg::KN_AW'(n_cl);
    assign gen_last = (i_reg + 1'b1)
                   == bsc_pkg::KN_AW'(n_cl) + bsc_pkg::KN_AW'(degree_reg) + 1'b1;

    // lerp terms
    logic signed [CW-1:0]             p0_c;
    logic signed [CW-1:0]             p1_c;
    logic signed [bsc_pkg::MAG_W-1:0] diff;
    logic signed [bsc_pkg::PROD_W-1:0] rnd_sum;
    logic signed [bsc_pkg::PROD_W-1:0] rnd_shift;

    assign p0_c = p0_reg[c_reg * CW +: CW];
    assign p1_c = p1_reg[c_reg * CW +: CW];
    assign diff = bsc_pkg::MAG_W'(p1_c) - bsc_pkg::MAG_W'(p0_c);
    assign rnd_sum = prod_reg + HALF;
    assign rnd_shift = rnd_sum >>> FB;

    // search terms
    logic [bsc_pkg::CNT_W:0]   mid_sum;
    logic [bsc_pkg::CNT_W-1:0] mid_new;
    logic [bsc_pkg::CNT_W-1:0] low_new;
    logic [bsc_pkg::CNT_W-1:0] high_new;
    logic [bsc_pkg::CNT_W-1:0] mid_cl;
    logic                      t_below;
    logic                      found;

    assign t_below  = t_reg < klo_reg;
    assign found    = !(t_below || (t_reg >= $signed(kn_rdata)));
    assign low_new  = t_below ? low_reg : mid_reg;
    assign high_new = t_below ? mid_reg : high_reg;
    assign mid_sum  = {1'b0, low_new} + {1'b0, high_new};
    assign mid_new  = mid_sum[bsc_pkg::CNT_W:1];

    function automatic logic [bsc_pkg::CNT_W-1:0] clamp_span(
        input logic [bsc_pkg::CNT_W-1:0] m,
        input logic [bsc_pkg::CNT_W-1:0] p,
        input logic [bsc_pkg::CNT_W-1:0] n);
        logic [bsc_pkg::CNT_W-1:0] r;
        r = m;
        if (r < p)
        begin
            r = p;
        end
        if (r > n - 1'b1)
        begin
            r = n - 1'b1;
        end
        return r;
    endfunction

    assign mid_cl = clamp_span(found ? mid_reg : mid_new, p_ext, n_cl);

    logic [bsc_pkg::KN_AW-1:0] kidx_a;
    logic [bsc_pkg::KN_AW-1:0] kidx_b;
    logic [bsc_pkg::KN_AW-1:0] pidx;

    assign pidx   = bsc_pkg::KN_AW'(span_reg) - bsc_pkg::KN_AW'(degree_reg)
                  + bsc_pkg::KN_AW'(j_reg);
    assign kidx_a = pidx;
    assign kidx_b = bsc_pkg::KN_AW'(span_reg) + bsc_pkg::KN_AW'(j_reg)
                  - bsc_pkg::KN_AW'(lv_reg) + 1'b1;

    always_comb
    begin
        case (state_reg)
            ST_RNG0:  kn_raddr = bsc_pkg::KN_AW'(degree_reg);
            ST_RNG1:  kn_raddr = bsc_pkg::KN_AW'(n_cl);
            ST_SRCH0: kn_raddr = bsc_pkg::KN_AW'(mid_reg);
            ST_SRCH1: kn_raddr = bsc_pkg::KN_AW'(mid_reg) + 1'b1;
            ST_K0:    kn_raddr = kidx_a;
            ST_K1:    kn_raddr = kidx_b;
            default:  kn_raddr = '0;
        endcase
    end

    assign wk_raddr = (state_reg == ST_K0) ? j_reg - 1'b1 : j_reg;
    assign pt_raddr = pidx[bsc_pkg::PT_AW-1:0];
    assign wk_we    = (state_reg == ST_LOADW) || (state_reg == ST_WR);
    assign wk_wdata = (state_reg == ST_LOADW) ? pt_rdata : res_reg;
    assign pt_we    = accept && (opcode == bsc_pkg::OP_LOAD_POINT)
                   && ({1'b0, slot} < 8'(bsc_pkg::MAX_POINTS));

    always_comb
    begin
        kn_we    = 1'b0;
        kn_waddr = i_reg;
        kn_wdata = '0;
        div_req.start = 1'b0;
        div_req.hi    = '0;
        div_req.lo    = '0;
        div_req.den   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                kn_we    = accept && (opcode == bsc_pkg::OP_LOAD_KNOT)
                        && ({1'b0, slot} < 8'(bsc_pkg::KNOT_DEPTH));
                kn_waddr = slot[bsc_pkg::KN_AW-1:0];
                kn_wdata = knot_value;
            end
            ST_GEN:
            begin
                kn_we    = gen_zero || gen_one;
                kn_wdata = gen_zero ? '0 : FX_ONE;
                div_req.start = !(gen_zero || gen_one);
                div_req.hi    = bsc_pkg::MAG_W'(i_reg - bsc_pkg::KN_AW'(degree_reg));
                div_req.lo    = FB'(gen_segs >> 1);
                div_req.den   = bsc_pkg::MAG_W'(gen_segs);
            end
            ST_GDIV:
            begin
                kn_we    = div_rsp.done;
                kn_wdata = CW'(div_rsp.quot);
            end
            ST_K2:
            begin
                div_req.start = !alpha_zero && !alpha_one;
                div_req.hi    = num_mag;
                div_req.den   = den_mag;
            end
            default:
            begin
                kn_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            degree_reg      <= 3'd3;
            point_count_reg <= '0;
            has_z_reg       <= 1'b0;
            has_m_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsc_pkg::REG_DEGREE:      degree_reg      <= cfg_data[bsc_pkg::DEG_W-1:0];
                    bsc_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data;
                    bsc_pkg::REG_HAS_Z:       has_z_reg       <= cfg_data[0];
                    bsc_pkg::REG_HAS_M:       has_m_reg       <= cfg_data[0];
                    default:                  has_m_reg       <= has_m_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        t_reg    <= param_t;
                        res_reg  <= '0;
                        stat_reg <= bsc_pkg::STAT_OK;
                        i_reg    <= '0;
                        if (opcode == bsc_pkg::OP_LOAD_POINT
                            || opcode == bsc_pkg::OP_LOAD_KNOT)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else if (n_cl == '0)
                        begin
                            stat_reg  <= bsc_pkg::STAT_EMPTY;
                            state_reg <= ST_DONE;
                        end
                        else if (p_ext >= n_cl)
                        begin
                            stat_reg  <= bsc_pkg::STAT_DEGREE;
                            state_reg <= ST_DONE;
                        end
                        else if (opcode == bsc_pkg::OP_GEN_KNOTS)
                        begin
                            state_reg <= ST_GEN;
                        end
                        else
                        begin
                            state_reg <= ST_RNG0;
                        end
                    end
                end
                ST_RNG0:
                begin
                    state_reg <= ST_RNG1;
                end
                ST_RNG1:
                begin
                    klo_reg   <= kn_rdata;
                    state_reg <= ST_RNG2;
                end
                ST_RNG2:
                begin
                    low_reg  <= p_ext;
                    high_reg <= n_cl;
                    mid_reg  <= bsc_pkg::CNT_W'(({1'b0, p_ext} + {1'b0, n_cl}) >> 1);
                    rnd_reg  <= '0;
                    j_reg    <= '0;
                    if (t_reg < klo_reg || t_reg > $signed(kn_rdata))
                    begin
                        stat_reg  <= bsc_pkg::STAT_RANGE;
                        state_reg <= ST_DONE;
                    end
                    else if (t_reg >= $signed(kn_rdata))
                    begin
                        span_reg  <= n_cl - 1'b1;
                        state_reg <= ST_LOAD;
                    end
                    else if (t_reg <= klo_reg)
                    begin
                        span_reg  <= p_ext;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        state_reg <= ST_SRCH0;
                    end
                end
                ST_SRCH0:
                begin
                    state_reg <= ST_SRCH1;
                end
                ST_SRCH1:
                begin
                    klo_reg   <= kn_rdata;
                    state_reg <= ST_SRCH2;
                end
                ST_SRCH2:
                begin
                    low_reg  <= low_new;
                    high_reg <= high_new;
                    mid_reg  <= mid_new;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (found || rnd_reg == bsc_pkg::RND_W'(bsc_pkg::ROUNDS - 1))
                    begin
                        span_reg  <= mid_cl;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        state_reg <= ST_SRCH0;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_LOADW;
                end
                ST_LOADW:
                begin
                    res_reg <= pt_rdata;
                    if (j_reg == degree_reg)
                    begin
                        lv_reg    <= bsc_pkg::DEG_W'(1);
                        state_reg <= (degree_reg == '0) ? ST_DONE : ST_LV0;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LV0:
                begin
                    state_reg <= ST_LV1;
                end
                ST_LV1:
                begin
                    p1_reg    <= wk_rdata;
                    state_reg <= ST_K0;
                end
                ST_K0:
                begin
                    state_reg <= ST_K1;
                end
                ST_K1:
                begin
                    ka_reg    <= kn_rdata;
                    p0_reg    <= wk_rdata;
                    state_reg <= ST_K2;
                end
                ST_K2:
                begin
                    c_reg <= '0;
                    if (alpha_zero)
                    begin
                        alpha_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                    else if (alpha_one)
                    begin
                        alpha_reg <= ALPHA_ONE;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        alpha_reg <= {1'b0, div_rsp.quot};
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= diff * $signed({1'b0, alpha_reg});
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    res_reg[c_reg * CW +: CW] <= p0_c + rnd_shift[CW-1:0];
                    c_reg <= c_reg + 1'b1;
                    state_reg <= (c_reg == 2'd3) ? ST_WR : ST_MUL;
                end
                ST_WR:
                begin
                    p1_reg <= p0_reg;
                    if (j_reg == lv_reg)
                    begin
                        if (lv_reg == degree_reg)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            lv_reg    <= lv_reg + 1'b1;
                            j_reg     <= degree_reg;
                            state_reg <= ST_LV0;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= ST_K0;
                    end
                end
                ST_GEN:
                begin
                    if (gen_zero || gen_one)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= gen_last ? ST_DONE : ST_GEN;
                    end
                    else
                    begin
                        state_reg <= ST_GDIV;
                    end
                end
                ST_GDIV:
                begin
                    if (div_rsp.done)
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= gen_last ? ST_DONE : ST_GEN;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= res_reg[0 +: CW];
                        out_y_reg     <= res_reg[CW +: CW];
                        out_z_reg     <= has_z_reg ? res_reg[2*CW +: CW] : '0;
                        out_m_reg     <= has_m_reg ? res_reg[3*CW +: CW] : '0;
                        out_stat_reg  <= stat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_m     = out_m_reg;
    assign status    = out_stat_reg;

    alpha_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> alpha_reg <= ALPHA_ONE)
        else $error("alpha above one");
    span_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> span_reg >= p_ext && span_reg < n_cl)
        else $error("span out of range");
    column_at_level: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> j_reg >= lv_reg && lv_reg <= degree_reg)
        else $error("de Boor index out of range");
    div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV || state_reg == ST_GDIV)
        else $error("divider result with no waiting step");

endmodule

/* dv/bspline_curve_evaluator_checker.sv */
// Checker for the B-spline curve evaluator: tracks stores and registers, predicts and compares.
module bspline_curve_evaluator_checker
    import bsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_AW-1:0]      cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [6:0]             slot,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic [COORD_WIDTH-1:0] in_z,
    input  logic [COORD_WIDTH-1:0] in_m,
    input  logic [COORD_WIDTH-1:0] knot_value,
    input  logic [COORD_WIDTH-1:0] param_t,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [COORD_WIDTH-1:0] out_x,
    input  logic [COORD_WIDTH-1:0] out_y,
    input  logic [COORD_WIDTH-1:0] out_z,
    input  logic [COORD_WIDTH-1:0] out_m,
    input  logic [1:0]             status,
    output int                     errors,
    output int                     pending,
    output int                     evals_ok
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = longint'(1) << FRAC_BITS;

    typedef struct {
        logic [COORD_WIDTH-1:0] x, y, z, m;
        logic [1:0]             st;
    } curve_point_t;

    longint       px [MAX_POINTS];
    longint       py [MAX_POINTS];
    longint       pz [MAX_POINTS];
    longint       pm [MAX_POINTS];
    longint       knots [KNOT_DEPTH];
    int unsigned  deg;
    int unsigned  npts;
    bit           use_z;
    bit           use_m;
    curve_point_t curve_q [$];

    function automatic longint knot(int unsigned i);
        return (i < KNOT_DEPTH) ? knots[i] : 0;
    endfunction

    function automatic longint blend(longint p0, longint p1, longint a);
        longint pr;
        pr = (p1 - p0) * a + (ONE >>> 1);
        return p0 + (pr >>> FRAC_BITS);
    endfunction

    function automatic longint weight(longint t, longint ka, longint kb);
        longint q;
        if (kb == ka)
            return 0;
        q = ((t - ka) * ONE) / (kb - ka);
        if (q < 0)
            q = 0;
        if (q > ONE)
            q = ONE;
        return q;
    endfunction

    function automatic int unsigned span_of(longint t, int unsigned p, int unsigned n);
        int unsigned lo, hi, mid;
        lo = p;
        hi = n;
        if (t >= knot(n))
            return n - 1;
        if (t <= knot(p))
            return p;
        mid = (lo + hi) / 2;
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (!(t < knot(mid) || t >= knot(mid + 1)))
                break;
            if (t < knot(mid))
                hi = mid;
            else
                lo = mid;
            mid = (lo + hi) / 2;
        end
        if (mid < p)
            mid = p;
        if (mid > n - 1)
            mid = n - 1;
        return mid;
    endfunction

    function automatic curve_point_t predict_point();
        curve_point_t r;
        int unsigned  n, p, sp, idx;
        longint       t, a;
        longint       tx [MAX_DEGREE+1];
        longint       ty [MAX_DEGREE+1];
        longint       tz [MAX_DEGREE+1];
        longint       tm [MAX_DEGREE+1];
        r = '{default: '0};
        n = (npts > MAX_POINTS) ? MAX_POINTS : npts;
        p = deg;
        if (opcode == OP_LOAD_POINT)
        begin
            if (slot < MAX_POINTS)
            begin
                px[slot] = longint'($signed(in_x));
                py[slot] = longint'($signed(in_y));
                pz[slot] = longint'($signed(in_z));
                pm[slot] = longint'($signed(in_m));
            end
        end
        else if (opcode == OP_LOAD_KNOT)
        begin
            if (slot < KNOT_DEPTH)
                knots[slot] = longint'($signed(knot_value));
        end
        else if (n == 0)
            r.st = STAT_EMPTY;
        else if (p >= n || p > MAX_DEGREE)
            r.st = STAT_DEGREE;
        else if (opcode == OP_GEN_KNOTS)
        begin
            for (int unsigned i = 0; i < n + p + 1 && i < KNOT_DEPTH; i++)
            begin
                if (i <= p)
                    knots[i] = 0;
                else if (i < n)
                    knots[i] = (longint'(i - p) * ONE + (n - p) / 2) / (n - p);
                else
                    knots[i] = ONE;
            end
        end
        else
        begin
            t = longint'($signed(param_t));
            if (t < knot(p) || t > knot(n))
                r.st = STAT_RANGE;
            else
            begin
                sp = span_of(t, p, n);
                for (int unsigned j = 0; j <= p; j++)
                begin
                    idx = (sp - p + j) % MAX_POINTS;
                    tx[j] = px[idx];
                    ty[j] = py[idx];
                    tz[j] = pz[idx];
                    tm[j] = pm[idx];
                end
                for (int unsigned lv = 1; lv <= p; lv++)
                begin
                    for (int unsigned j = p; j >= lv; j--)
                    begin
                        a = weight(t, knot(sp - p + j), knot(sp + j - lv + 1));
                        tx[j] = blend(tx[j-1], tx[j], a);
                        ty[j] = blend(ty[j-1], ty[j], a);
                        tz[j] = blend(tz[j-1], tz[j], a);
                        tm[j] = blend(tm[j-1], tm[j], a);
                    end
                end
                r.x = tx[p][COORD_WIDTH-1:0];
                r.y = ty[p][COORD_WIDTH-1:0];
                r.z = use_z ? tz[p][COORD_WIDTH-1:0] : '0;
                r.m = use_m ? tm[p][COORD_WIDTH-1:0] : '0;
                evals_ok++;
            end
        end
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h want %h", $realtime, field, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        curve_point_t w;
        if (!rst_n)
        begin
            deg = 3;
            npts = 0;
            use_z = 0;
            use_m = 0;
            curve_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEGREE:      deg = cfg_data[2:0];
                    REG_POINT_COUNT: npts = cfg_data[6:0];
                    REG_HAS_Z:       use_z = cfg_data[0];
                    REG_HAS_M:       use_m = cfg_data[0];
                    default:         use_m = use_m;
                endcase
            end
            if (in_valid && !in_stall)
                curve_q.insert(curve_q.size(), predict_point());
            if (out_valid && !out_stall)
            begin
                if (curve_q.size() == 0)
                    report("unexpected word", status, 0);
                else
                begin
                    w = curve_q.pop_front();
                    if (out_x !== w.x)
                        report("out_x", out_x, w.x);
                    if (out_y !== w.y)
                        report("out_y", out_y, w.y);
                    if (out_z !== w.z)
                        report("out_z", out_z, w.z);
                    if (out_m !== w.m)
                        report("out_m", out_m, w.m);
                    if (status !== w.st)
                        report("status", status, w.st);
                end
            end
        end
        pending = curve_q.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
        evals_ok = 0;
    end
endmodule

/* dv/bspline_curve_evaluator_tb.sv */
// Testbench top for the B-spline curve evaluator: stimulus, idling and verdict.
module bspline_curve_evaluator_tb;
    import bsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 40000;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic [CFG_AW-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 0;
    logic                   in_stall;
    logic [1:0]             opcode = OP_LOAD_POINT;
    logic [6:0]             slot = '0;
    logic [COORD_WIDTH-1:0] in_x = '0;
    logic [COORD_WIDTH-1:0] in_y = '0;
    logic [COORD_WIDTH-1:0] in_z = '0;
    logic [COORD_WIDTH-1:0] in_m = '0;
    logic [COORD_WIDTH-1:0] knot_value = '0;
    logic [COORD_WIDTH-1:0] param_t = '0;
    logic                   out_valid;
    logic                   out_stall = 0;
    logic [COORD_WIDTH-1:0] out_x, out_y, out_z, out_m;
    logic [1:0]             status;
    int                     errors, pending, evals_ok;
    bit                     calm = 0;
    int                     words_sent = 0;
    int                     settings = 0;
    int                     quiet = 0;

    bspline_curve_evaluator dut (.*);

    bspline_curve_evaluator_checker checker_i (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 38);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog expired");
                $display("[bspline_curve_evaluator] ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(logic [1:0] op, logic [6:0] s, logic [31:0] k, logic [31:0] t);
        while (!calm && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode     <= op;
        slot       <= s;
        in_x       <= $urandom;
        in_y       <= $urandom;
        in_z       <= $urandom;
        in_m       <= $urandom;
        knot_value <= k;
        param_t    <= t;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned val);
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_curve(int unsigned d, int unsigned n, bit z, bit m);
        drain();
        write_reg(REG_DEGREE, d);
        write_reg(REG_POINT_COUNT, n);
        write_reg(REG_HAS_Z, z);
        write_reg(REG_HAS_M, m);
        settings++;
    endtask

    task automatic eval_at(logic [31:0] t);
        send_word(OP_EVALUATE, 7'($urandom), $urandom, t);
    endtask

    task automatic random_word();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)
            send_word(OP_LOAD_POINT, 7'($urandom), $urandom, $urandom);
        else if (r < 22)
            send_word(OP_LOAD_KNOT, 7'($urandom), $urandom_range(65536), $urandom);
        else if (r < 25)
            send_word(OP_LOAD_KNOT, 7'($urandom), $urandom, $urandom);
        else if (r < 30)
            send_word(OP_GEN_KNOTS, 7'($urandom), $urandom, $urandom);
        else if (r < 88)
            eval_at($urandom_range(65536));
        else if (r < 94)
            eval_at($urandom);
        else
            eval_at($urandom_range(1) ? 32'h0 : 32'h0001_0000);
    endtask

    initial
    begin
        int unsigned d, n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every store entry gets written before any evaluation reads it
        calm = 1;
        for (int i = 0; i < MAX_POINTS; i++)
            send_word(OP_LOAD_POINT, 7'(i), $urandom, $urandom);
        for (int i = 0; i < KNOT_DEPTH; i++)
            send_word(OP_LOAD_KNOT, 7'(i), i * 1024, $urandom);
        calm = 0;

        set_curve(3, 4, 1'b1, 1'b1);
        eval_at(32'h0000_8000);
        send_word(OP_GEN_KNOTS, 7'd0, 0, 0);
        eval_at(32'h0);
        eval_at(32'h0001_0000);
        eval_at(32'h0000_8000);
        eval_at(32'hFFFF_FFFF);
        eval_at(32'h0001_0001);
        eval_at(32'h7FFF_FFFF);
        eval_at(32'h8000_0000);
        send_word(OP_LOAD_KNOT, 7'd127, 32'h7FFF_FFFF, 0);
        send_word(OP_LOAD_POINT, 7'd64, 0, 0);
        send_word(OP_LOAD_KNOT, 7'd71, 32'h8000_0000, 0);
        send_word(OP_LOAD_KNOT, 7'd4, 32'h0000_0000, 0);
        send_word(OP_LOAD_KNOT, 7'd5, 32'h0000_0000, 0);
        eval_at(32'h0);
        eval_at(32'h0000_4000);
        set_curve(0, 0, 1'b0, 1'b0);
        eval_at(32'h0);
        send_word(OP_GEN_KNOTS, 7'd0, 0, 0);
        set_curve(4, 4, 1'b0, 1'b1);
        eval_at(32'h0);
        send_word(OP_GEN_KNOTS, 7'd0, 0, 0);
        set_curve(0, 1, 1'b1, 1'b0);
        send_word(OP_GEN_KNOTS, 7'd0, 0, 0);
        eval_at(32'h0);
        eval_at(32'h0001_0000);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin d = 7; n = 64; end
                1: begin d = 7; n = 127; end
                2: begin d = 0; n = 1; end
                3: begin d = 1; n = 2; end
                4: begin d = 5; n = 3; end
                default:
                begin
                    n = $urandom_range(1, 20);
                    d = $urandom_range(0, 7);
                end
            endcase
            set_curve(d, n, 1'($urandom_range(1)), 1'($urandom_range(1)));
            calm = (ph == 6);
            send_word(OP_GEN_KNOTS, 7'd0, 0, 0);
            for (int i = 0; i < 110; i++)
            begin
                if (ph == 3 && i == 55)
                    drain();
                random_word();
            end
            calm = 0;
        end

        drain();
        repeat (200) @(posedge clk);
        $display("sent %0d words over %0d register settings, %0d in-range evaluations",
                 words_sent, settings, evals_ok);
        if (errors == 0 && pending == 0)
            $display("[bspline_curve_evaluator] OK");
        else
            $display("[bspline_curve_evaluator] ERROR");
        $finish;
    end
endmodule
